### sv/dot_matrix_text_rasterizer_assert.svh
// Assertion macros for the dot-matrix text rasterizer.
// Needs clk and rst_n in the scope of the module that includes it.
`ifndef DOT_MATRIX_TEXT_RASTERIZER_ASSERT_SVH
`define DOT_MATRIX_TEXT_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define DMTR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define DMTR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dmtr_pkg.sv
// Shared types, constants and the 5x7 glyph ROM of the dot-matrix text rasterizer.
// No dependencies.
package dmtr_pkg;

    localparam int GLYPH_COUNT = 128;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_DOTS  = GLYPH_ROWS * GLYPH_COLS;
    localparam int COL_W       = $clog2(GLYPH_COLS);

    localparam logic [7:0] CHAR_DOT = 8'h2E;

    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_CHAR  = 1'b1;

    localparam logic [1:0] CFG_DOT_SPAN   = 2'd0;
    localparam logic [1:0] CFG_LINE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_FILL_COLOR = 2'd2;

    localparam logic [3:0]  DOT_SPAN_RST   = 4'd2;
    localparam logic [10:0] LINE_LIMIT_RST = 11'd144;
    localparam logic [7:0]  FILL_COLOR_RST = 8'd255;

    // Row 0 in the top bits, left column first within a row.
    typedef logic [GLYPH_DOTS-1:0] glyph_t;

    typedef struct packed {
        logic [3:0]  dot_span;
        logic [10:0] line_limit;
        logic [7:0]  fill_color;
    } cfg_t;

    // One queued job for the dot scanner; an all-zero mask means a no-dot result.
    typedef struct packed {
        glyph_t      mask;
        logic [13:0] x0;
        logic [13:0] y0;
        logic [3:0]  side;
        logic [7:0]  color;
        logic [10:0] width;
    } entry_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_FINISH
    } front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } back_state_t;

    function automatic glyph_t glyph_mask(input logic [7:0] code);
        glyph_t m;
        m = '0;
        if ({1'b0, code} < 9'(GLYPH_COUNT)) begin
            case (code)
                8'h2D: m = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
                8'h27: m = {5'h06, 5'h06, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
                8'h3A: m = {5'h00, 5'h06, 5'h06, 5'h00, 5'h06, 5'h06, 5'h00};
                8'h2E: m = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
                8'h2F: m = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
                8'h30: m = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
                8'h31: m = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
                8'h32: m = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
                8'h33: m = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
                8'h34: m = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
                8'h35: m = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
                8'h36: m = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
                8'h37: m = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
                8'h38: m = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
                8'h39: m = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
                8'h41: m = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
                8'h42: m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
                8'h43: m = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
                8'h44: m = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
                8'h45: m = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
                8'h46: m = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
                8'h47: m = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
                8'h48: m = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
                8'h49: m = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
                8'h4A: m = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
                8'h4B: m = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
                8'h4C: m = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
                8'h4D: m = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
                8'h4E: m = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
                8'h4F: m = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
                8'h50: m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
                8'h51: m = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
                8'h52: m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
                8'h53: m = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
                8'h54: m = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
                8'h55: m = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
                8'h56: m = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
                8'h57: m = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
                8'h58: m = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
                8'h59: m = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
                8'h5A: m = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
                default: m = '0;
            endcase
        end
        return m;
    endfunction

endpackage

### sv/dmtr_front.sv
// Front end: accepts items, keeps the string state, runs the fit division on begin.
// Emits one queue entry per item. Depends on dmtr_pkg.
module dmtr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dmtr_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic signed [11:0]    origin_x,
    input  logic signed [11:0]    origin_y,
    input  logic [7:0]            text_length,
    input  logic [7:0]            char_code,
    output logic                  q_push,
    output dmtr_pkg::entry_t      q_entry,
    input  logic                  q_full
);

    localparam int DIV_STEPS = 11;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    dmtr_pkg::front_state_t state_reg, state_next;

    logic [13:0]       cursor_x_reg, cursor_x_next;
    logic [11:0]       row_y_reg, row_y_next;
    logic [11:0]       origin_x_reg, origin_x_next;
    logic [7:0]        char_index_reg, char_index_next;
    logic [7:0]        draw_count_reg, draw_count_next;
    logic              trunc_reg, trunc_next;
    logic [7:0]        len_reg, len_next;
    logic [6:0]        pitch_reg, pitch_next;
    logic [10:0]       quo_reg, quo_next;
    logic [6:0]        rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [6:0]  pitch;
    logic [13:0] origin_sx;
    logic [13:0] row_sx;
    logic        dropped;
    logic        last_pos;
    logic [7:0]  code_sel;
    logic [13:0] cursor_adv;
    logic [13:0] width_cur;
    logic [13:0] width_adv;
    logic [7:0]  trial;
    logic        trial_ge;
    logic [7:0]  dc_fin;
    logic        tr_fin;
    logic [14:0] prod;

    assign pitch     = 7'({cfg.dot_span, 2'b00}) + 7'(cfg.dot_span) + 7'd6;
    assign origin_sx = {{2{origin_x_reg[11]}}, origin_x_reg};
    assign row_sx    = {{2{row_y_reg[11]}}, row_y_reg};

    assign dropped    = char_index_reg >= draw_count_reg;
    assign last_pos   = ({1'b0, char_index_reg} + 9'd1) == {1'b0, draw_count_reg};
    assign code_sel   = (trunc_reg && last_pos) ? dmtr_pkg::CHAR_DOT : char_code;
    assign cursor_adv = cursor_x_reg + {7'b0, pitch};
    assign width_cur  = cursor_x_reg - origin_sx;
    assign width_adv  = cursor_adv - origin_sx;

    // One restoring-division step per cycle.
    assign trial    = {rem_reg, quo_reg[10]};
    assign trial_ge = trial >= {1'b0, pitch_reg};

    always_comb
    begin
        if (quo_reg == '0) begin
            dc_fin = '0;
            tr_fin = 1'b0;
        end else if ({3'b0, len_reg} > quo_reg) begin
            dc_fin = quo_reg[7:0];
            tr_fin = 1'b1;
        end else begin
            dc_fin = len_reg;
            tr_fin = 1'b0;
        end
    end

    assign prod = {7'b0, dc_fin} * {8'b0, pitch_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= dmtr_pkg::FR_IDLE;
            cursor_x_reg   <= '0;
            row_y_reg      <= '0;
            origin_x_reg   <= '0;
            char_index_reg <= '0;
            draw_count_reg <= '0;
            trunc_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_x_reg   <= cursor_x_next;
            row_y_reg      <= row_y_next;
            origin_x_reg   <= origin_x_next;
            char_index_reg <= char_index_next;
            draw_count_reg <= draw_count_next;
            trunc_reg      <= trunc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        pitch_reg <= pitch_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cursor_x_next   = cursor_x_reg;
        row_y_next      = row_y_reg;
        origin_x_next   = origin_x_reg;
        char_index_next = char_index_reg;
        draw_count_next = draw_count_reg;
        trunc_next      = trunc_reg;
        len_next        = len_reg;
        pitch_next      = pitch_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        in_ready        = 1'b0;
        q_push          = 1'b0;
        q_entry         = '0;

        case (state_reg)
            dmtr_pkg::FR_IDLE:
            begin
                in_ready = !q_full;
                if (in_valid && !q_full) begin
                    if (action == dmtr_pkg::ACT_BEGIN) begin
                        origin_x_next   = origin_x;
                        row_y_next      = origin_y;
                        cursor_x_next   = {{2{origin_x[11]}}, origin_x};
                        char_index_next = '0;
                        len_next        = text_length;
                        pitch_next      = pitch;
                        quo_next        = cfg.line_limit;
                        rem_next        = '0;
                        step_next       = '0;
                        state_next      = dmtr_pkg::FR_DIV;
                    end else begin
                        q_push        = 1'b1;
                        q_entry.x0    = cursor_x_reg;
                        q_entry.y0    = row_sx;
                        q_entry.side  = cfg.dot_span;
                        q_entry.color = cfg.fill_color;
                        if (dropped) begin
                            q_entry.width = width_cur[10:0];
                        end else begin
                            q_entry.mask    = dmtr_pkg::glyph_mask(code_sel);
                            q_entry.width   = width_adv[10:0];
                            cursor_x_next   = cursor_adv;
                            char_index_next = char_index_reg + 8'd1;
                        end
                    end
                end
            end
            dmtr_pkg::FR_DIV:
            begin
                rem_next  = trial_ge ? 7'(trial - {1'b0, pitch_reg}) : trial[6:0];
                quo_next  = {quo_reg[9:0], trial_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = dmtr_pkg::FR_FINISH;
                end
            end
            dmtr_pkg::FR_FINISH:
            begin
                // quo_reg now holds the number of characters that fit
                if (!q_full) begin
                    q_push          = 1'b1;
                    q_entry.width   = prod[10:0];
                    draw_count_next = dc_fin;
                    trunc_next      = tr_fin;
                    state_next      = dmtr_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = dmtr_pkg::FR_IDLE;
            end
        endcase
    end

endmodule

### sv/dmtr_queue.sv
// Small FIFO of scanner jobs between front and back end.
// Depends on dmtr_pkg.
module dmtr_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dmtr_pkg::entry_t      din,
    output logic                  full,
    input  logic                  pop,
    output dmtr_pkg::entry_t      dout,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dmtr_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

### sv/dmtr_back.sv
// Back end: scans a glyph mask one dot per cycle, holding on a lit dot while the output
// register is full, and drives the registered result port. Depends on dmtr_pkg.
module dmtr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  dmtr_pkg::entry_t      q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  dot_valid,
    output logic signed [13:0]    dot_x,
    output logic signed [13:0]    dot_y,
    output logic [3:0]            dot_side,
    output logic [7:0]            dot_color,
    output logic [10:0]           text_width,
    output logic                  last
);

    localparam int DOTS = dmtr_pkg::GLYPH_DOTS;
    localparam int CW   = dmtr_pkg::COL_W;

    dmtr_pkg::back_state_t state_reg, state_next;

    dmtr_pkg::glyph_t mask_reg, mask_next;
    logic [13:0]      x_reg, x_next;
    logic [13:0]      y_reg, y_next;
    logic [13:0]      x0_reg, x0_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [4:0]       dp_reg, dp_next;
    logic [3:0]       side_reg, side_next;
    logic [7:0]       color_reg, color_next;
    logic [10:0]      width_reg, width_next;

    logic             o_valid_reg, o_valid_next;
    logic             o_last_reg, o_last_next;
    logic             o_dot_reg, o_dot_next;
    logic [13:0]      o_x_reg, o_x_next;
    logic [13:0]      o_y_reg, o_y_next;
    logic [3:0]       o_side_reg, o_side_next;
    logic [7:0]       o_color_reg, o_color_next;
    logic [10:0]      o_width_reg, o_width_next;

    logic adv;
    logic lit;
    logic rest_zero;

    assign adv       = !o_valid_reg || out_ready;
    assign lit       = mask_reg[DOTS-1];
    assign rest_zero = mask_reg[DOTS-2:0] == '0;

    assign out_valid  = o_valid_reg;
    assign dot_valid  = o_dot_reg;
    assign dot_x      = o_x_reg;
    assign dot_y      = o_y_reg;
    assign dot_side   = o_side_reg;
    assign dot_color  = o_color_reg;
    assign text_width = o_width_reg;
    assign last       = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= dmtr_pkg::BK_IDLE;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg    <= mask_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        x0_reg      <= x0_next;
        col_reg     <= col_next;
        dp_reg      <= dp_next;
        side_reg    <= side_next;
        color_reg   <= color_next;
        width_reg   <= width_next;
        o_last_reg  <= o_last_next;
        o_dot_reg   <= o_dot_next;
        o_x_reg     <= o_x_next;
        o_y_reg     <= o_y_next;
        o_side_reg  <= o_side_next;
        o_color_reg <= o_color_next;
        o_width_reg <= o_width_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        mask_next    = mask_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        x0_next      = x0_reg;
        col_next     = col_reg;
        dp_next      = dp_reg;
        side_next    = side_reg;
        color_next   = color_reg;
        width_next   = width_reg;
        o_valid_next = o_valid_reg && !out_ready;
        o_last_next  = o_last_reg;
        o_dot_next   = o_dot_reg;
        o_x_next     = o_x_reg;
        o_y_next     = o_y_reg;
        o_side_next  = o_side_reg;
        o_color_next = o_color_reg;
        o_width_next = o_width_reg;
        q_pop        = 1'b0;

        case (state_reg)
            dmtr_pkg::BK_IDLE:
            begin
                if (!q_empty) begin
                    if (q_data.mask == '0) begin
                        // single no-dot result closes the item
                        if (adv) begin
                            q_pop        = 1'b1;
                            o_valid_next = 1'b1;
                            o_dot_next   = 1'b0;
                            o_x_next     = '0;
                            o_y_next     = '0;
                            o_side_next  = '0;
                            o_color_next = '0;
                            o_width_next = q_data.width;
                            o_last_next  = 1'b1;
                        end
                    end else begin
                        q_pop      = 1'b1;
                        mask_next  = q_data.mask;
                        x_next     = q_data.x0;
                        x0_next    = q_data.x0;
                        y_next     = q_data.y0;
                        col_next   = '0;
                        dp_next    = {1'b0, q_data.side} + 5'd1;
                        side_next  = q_data.side;
                        color_next = q_data.color;
                        width_next = q_data.width;
                        state_next = dmtr_pkg::BK_SCAN;
                    end
                end
            end
            dmtr_pkg::BK_SCAN:
            begin
                if (lit && adv) begin
                    o_valid_next = 1'b1;
                    o_dot_next   = 1'b1;
                    o_x_next     = x_reg;
                    o_y_next     = y_reg;
                    o_side_next  = side_reg;
                    o_color_next = color_reg;
                    o_width_next = width_reg;
                    o_last_next  = rest_zero;
                end
                // hold on a lit dot while the output register is full
                if (!lit || adv) begin
                    mask_next = mask_reg << 1;
                    if (col_reg == CW'(dmtr_pkg::GLYPH_COLS - 1)) begin
                        col_next = '0;
                        x_next   = x0_reg;
                        y_next   = y_reg + {9'b0, dp_reg};
                    end else begin
                        col_next = col_reg + CW'(1);
                        x_next   = x_reg + {9'b0, dp_reg};
                    end
                    if (rest_zero) begin
                        state_next = dmtr_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dmtr_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

### sv/dot_matrix_text_rasterizer.sv
// Top level of the 5x7 dot-matrix text rasterizer: config registers, front, queue, back.
// Depends on dmtr_pkg, dmtr_front, dmtr_queue, dmtr_back and the assertion header.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------------------
//   cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in       | in_valid / in_ready   | action, origin_x, origin_y, text_length, char_code
//   out      | out_valid / out_ready | dot_valid, dot_x, dot_y, dot_side, dot_color,
//            |                       | text_width, last
//
// A begin item holds the front end through acceptance, 11 steps of the bit-serial
// division of the line limit by the character pitch, and queuing of the width result.
// A character item is queued as it is accepted; the back end loads it, then scans one
// glyph dot per cycle up to the last lit one (at most 35) unless the output stalls.
// The queue lets the front end take new items while the back end scans. Reset is
// asynchronous and clears all control state; config writes never stall.
`include "dot_matrix_text_rasterizer_assert.svh"

module dot_matrix_text_rasterizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [10:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic signed [11:0]    origin_x,
    input  logic signed [11:0]    origin_y,
    input  logic [7:0]            text_length,
    input  logic [7:0]            char_code,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  dot_valid,
    output logic signed [13:0]    dot_x,
    output logic signed [13:0]    dot_y,
    output logic [3:0]            dot_side,
    output logic [7:0]            dot_color,
    output logic [10:0]           text_width,
    output logic                  last
);

    dmtr_pkg::cfg_t   cfg_reg, cfg_next;
    dmtr_pkg::entry_t push_entry;
    dmtr_pkg::entry_t head_entry;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    logic             begin_taken;

    // Config writes are never stalled.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                dmtr_pkg::CFG_DOT_SPAN:   cfg_next.dot_span   = cfg_data[3:0];
                dmtr_pkg::CFG_LINE_LIMIT: cfg_next.line_limit = cfg_data;
                dmtr_pkg::CFG_FILL_COLOR: cfg_next.fill_color = cfg_data[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.dot_span   <= dmtr_pkg::DOT_SPAN_RST;
            cfg_reg.line_limit <= dmtr_pkg::LINE_LIMIT_RST;
            cfg_reg.fill_color <= dmtr_pkg::FILL_COLOR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classify items, track the pen, push one job per item.
    dmtr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .text_length (text_length),
        .char_code   (char_code),
        .q_push      (q_push),
        .q_entry     (push_entry),
        .q_full      (q_full)
    );

    // Decouple the two sides.
    dmtr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_entry),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (head_entry),
        .empty (q_empty)
    );

    // Back end: scan glyph dots and drive the result port.
    dmtr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (head_entry),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dot_valid  (dot_valid),
        .dot_x      (dot_x),
        .dot_y      (dot_y),
        .dot_side   (dot_side),
        .dot_color  (dot_color),
        .text_width (text_width),
        .last       (last)
    );

    assign begin_taken = in_valid && in_ready && (action == dmtr_pkg::ACT_BEGIN);

    // A no-dot result is always the only result of its item.
    `DMTR_ASSERT_IMP(a_nodot_is_last, out_valid && !dot_valid, last, "no-dot result without last")
    // The front end never pushes into a full queue.
    `DMTR_ASSERT_IMP(a_no_overflow, q_push, !q_full, "push into full queue")
    // A begin item blocks the input while the fit division runs.
    `DMTR_ASSERT_NXT(a_begin_blocks, begin_taken, !in_ready, "input taken during division")

endmodule
